@@ rtl/core/assert_macros.svh @@
// Assertion macros for the joystick decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define JDH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every rising clk edge, reset included.
`define JDH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

@@ rtl/core/jdh_pkg.sv @@
// Types, codes and reset values for the joystick direction decoder.
package jdh_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TICK_BITS       = 17;
    localparam int TIMEOUT_BITS    = 16;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int EVENT_BITS      = 3;
    localparam int OUT_DATA_BITS   = 8;

    localparam logic [TICK_BITS-1:0] TICKS_MAX = {TICK_BITS{1'b1}};

    localparam logic [15:0] CENTER_LOW_RST   = 16'd1900;
    localparam logic [15:0] CENTER_HIGH_RST  = 16'd2300;
    localparam logic [15:0] PRESS_LOW_RST    = 16'd500;
    localparam logic [15:0] PRESS_HIGH_RST   = 16'd3600;
    localparam logic [15:0] HOLD_TIMEOUT_RST = 16'd6000;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_CENTER_LOW   = 3'd0,
        REG_CENTER_HIGH  = 3'd1,
        REG_PRESS_LOW    = 3'd2,
        REG_PRESS_HIGH   = 3'd3,
        REG_HOLD_TIMEOUT = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_LEFT  = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_RIGHT = 3'd3,
        MODE_UP    = 3'd4,
        MODE_ERROR = 3'd5
    } mode_t;

    localparam logic [EVENT_BITS-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_BITS-1:0] EV_LEFT    = 3'd1;
    localparam logic [EVENT_BITS-1:0] EV_DOWN    = 3'd2;
    localparam logic [EVENT_BITS-1:0] EV_RIGHT   = 3'd3;
    localparam logic [EVENT_BITS-1:0] EV_UP      = 3'd4;
    localparam logic [EVENT_BITS-1:0] EV_ERROR   = 3'd5;
    localparam logic [EVENT_BITS-1:0] EV_HOLDING = 3'd6;

    typedef struct packed {
        mode_t                mode;
        logic [TICK_BITS-1:0] hold_ticks;
    } jdh_state_t;

endpackage

@@ rtl/core/joystick_direction_with_hold_timeout_top.sv @@
// Top level of the joystick direction decoder with hold timeout.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+-------------------------------------
//  s_axis  | in  | s_tvalid/s_tready  | x_sample, y_sample, tick
//  m_axis  | out | m_tvalid/m_tready  | event_res
//  cfg     | in  | cfg_we             | cfg_addr selects register, cfg_data
//
//  One sample in, one event out; a new sample is taken every cycle unless
//  m_tready stalls the result. The decode and state update sit between the
//  input transfer and the result register.
//  The result register frees in the same cycle it is taken, so only a stall
//  on m_tready holds back s_tready.
//  Reset returns the mode to idle, clears the hold counter and loads the
//  default thresholds.
`include "assert_macros.svh"

module joystick_direction_with_hold_timeout_top #(
    parameter int SAMPLE_BITS = jdh_pkg::SAMPLE_BITS_DEF,
    localparam int IN_BITS    = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // low to high: x_sample, y_sample, tick, zero fill
    input  logic [IN_BITS-1:0]                   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // low to high: event_res, zero fill
    output logic [jdh_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    input  logic                                 cfg_we,
    input  logic [jdh_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [jdh_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic [SAMPLE_BITS-1:0]           center_low_reg;
    logic [SAMPLE_BITS-1:0]           center_high_reg;
    logic [SAMPLE_BITS-1:0]           press_low_reg;
    logic [SAMPLE_BITS-1:0]           press_high_reg;
    logic [jdh_pkg::TIMEOUT_BITS-1:0] hold_timeout_reg;

    jdh_pkg::jdh_state_t              state_reg;
    jdh_pkg::jdh_state_t              state_next;
    logic                             valid_reg;
    logic [jdh_pkg::EVENT_BITS-1:0]   event_reg;
    logic [jdh_pkg::EVENT_BITS-1:0]   event_next;
    logic                             s_xfer;

    assign s_tready = !valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(jdh_pkg::OUT_DATA_BITS - jdh_pkg::EVENT_BITS){1'b0}}, event_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_low_reg   <= jdh_pkg::CENTER_LOW_RST[SAMPLE_BITS-1:0];
            center_high_reg  <= jdh_pkg::CENTER_HIGH_RST[SAMPLE_BITS-1:0];
            press_low_reg    <= jdh_pkg::PRESS_LOW_RST[SAMPLE_BITS-1:0];
            press_high_reg   <= jdh_pkg::PRESS_HIGH_RST[SAMPLE_BITS-1:0];
            hold_timeout_reg <= jdh_pkg::HOLD_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                jdh_pkg::REG_CENTER_LOW:   center_low_reg   <= cfg_data[SAMPLE_BITS-1:0];
                jdh_pkg::REG_CENTER_HIGH:  center_high_reg  <= cfg_data[SAMPLE_BITS-1:0];
                jdh_pkg::REG_PRESS_LOW:    press_low_reg    <= cfg_data[SAMPLE_BITS-1:0];
                jdh_pkg::REG_PRESS_HIGH:   press_high_reg   <= cfg_data[SAMPLE_BITS-1:0];
                jdh_pkg::REG_HOLD_TIMEOUT: hold_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    jdh_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .x_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .y_sample     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .tick         (s_tdata[2*SAMPLE_BITS]),
        .center_low   (center_low_reg),
        .center_high  (center_high_reg),
        .press_low    (press_low_reg),
        .press_high   (press_high_reg),
        .hold_timeout (hold_timeout_reg),
        .cur          (state_reg),
        .nxt          (state_next),
        .event_res    (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= jdh_pkg::MODE_IDLE;
            state_reg.hold_ticks <= '0;
            valid_reg            <= 1'b0;
        end
        else
        begin
            if (s_xfer)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload: load on every input transfer
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            event_reg <= event_next;
        end
    end

    `JDH_ASSERT(a_xfer_gives_result, s_xfer |=> m_tvalid, "accepted sample left no result")
    `JDH_ASSERT(a_error_matches_mode,
        s_xfer |=> ((event_reg == jdh_pkg::EV_ERROR) == (state_reg.mode == jdh_pkg::MODE_ERROR)),
        "error event and error mode disagree")
    `JDH_ASSERT(a_holding_matches_mode,
        s_xfer |=> ((event_reg == jdh_pkg::EV_HOLDING) ==
            (state_reg.mode == jdh_pkg::MODE_LEFT || state_reg.mode == jdh_pkg::MODE_DOWN ||
             state_reg.mode == jdh_pkg::MODE_RIGHT || state_reg.mode == jdh_pkg::MODE_UP)),
        "holding event and hold mode disagree")
    `JDH_ASSERT(a_state_holds_idle, !s_xfer |=> $stable(state_reg),
        "state moved without an input transfer")

endmodule

@@ rtl/core/jdh_step.sv @@
// Per-sample next-state and event logic of the joystick decoder.
module jdh_step #(
    parameter int SAMPLE_BITS = jdh_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]            x_sample,
    input  logic [SAMPLE_BITS-1:0]            y_sample,
    input  logic                              tick,
    input  logic [SAMPLE_BITS-1:0]            center_low,
    input  logic [SAMPLE_BITS-1:0]            center_high,
    input  logic [SAMPLE_BITS-1:0]            press_low,
    input  logic [SAMPLE_BITS-1:0]            press_high,
    input  logic [jdh_pkg::TIMEOUT_BITS-1:0]  hold_timeout,
    input  jdh_pkg::jdh_state_t               cur,
    output jdh_pkg::jdh_state_t               nxt,
    output logic [jdh_pkg::EVENT_BITS-1:0]    event_res
);

    logic [jdh_pkg::TICK_BITS-1:0] ticks_inc;
    logic                          timed_out;
    logic                          released;
    logic                          x_in_band;
    logic                          y_in_band;
    logic                          centred;

    assign x_in_band = (x_sample >= center_low) && (x_sample <= center_high);
    assign y_in_band = (y_sample >= center_low) && (y_sample <= center_high);
    assign centred   = (x_sample > center_low) && (x_sample < center_high) &&
                       (y_sample > center_low) && (y_sample < center_high);

    // saturate the elapsed counter rather than wrap
    assign ticks_inc = (tick && (cur.hold_ticks != jdh_pkg::TICKS_MAX)) ?
                       cur.hold_ticks + 1'b1 : cur.hold_ticks;
    assign timed_out = ticks_inc > {1'b0, hold_timeout};

    always_comb
    begin
        case (cur.mode)
            jdh_pkg::MODE_LEFT:  released = x_sample >= center_low;
            jdh_pkg::MODE_DOWN:  released = y_sample >= center_low;
            jdh_pkg::MODE_RIGHT: released = x_sample <= center_high;
            default:             released = y_sample <= center_high;
        endcase
    end

    always_comb
    begin
        nxt       = cur;
        event_res = jdh_pkg::EV_NONE;
        case (cur.mode)
            jdh_pkg::MODE_ERROR:
            begin
                if (x_in_band && y_in_band)
                begin
                    nxt.mode = jdh_pkg::MODE_IDLE;
                end
                else
                begin
                    event_res = jdh_pkg::EV_ERROR;
                end
            end
            jdh_pkg::MODE_LEFT, jdh_pkg::MODE_DOWN,
            jdh_pkg::MODE_RIGHT, jdh_pkg::MODE_UP:
            begin
                nxt.hold_ticks = ticks_inc;
                if (timed_out)
                begin
                    nxt.mode  = jdh_pkg::MODE_ERROR;
                    event_res = jdh_pkg::EV_ERROR;
                end
                else if (released)
                begin
                    nxt.mode  = jdh_pkg::MODE_IDLE;
                    event_res = cur.mode;
                end
                else
                begin
                    event_res = jdh_pkg::EV_HOLDING;
                end
            end
            default:
            begin
                nxt.mode = jdh_pkg::MODE_IDLE;
                if (!centred)
                begin
                    // first deflection wins: left, down, right, up
                    if (x_sample < press_low)
                    begin
                        nxt.mode = jdh_pkg::MODE_LEFT;
                    end
                    else if (y_sample < press_low)
                    begin
                        nxt.mode = jdh_pkg::MODE_DOWN;
                    end
                    else if (x_sample > press_high)
                    begin
                        nxt.mode = jdh_pkg::MODE_RIGHT;
                    end
                    else if (y_sample > press_high)
                    begin
                        nxt.mode = jdh_pkg::MODE_UP;
                    end
                    if (nxt.mode != jdh_pkg::MODE_IDLE)
                    begin
                        nxt.hold_ticks = '0;
                        event_res      = jdh_pkg::EV_HOLDING;
                    end
                end
            end
        endcase
    end

endmodule
